### src/olid_pkg.sv
// Package for the ordered list block: field widths, operation and status codes,
// controller state type and the command/status structs between control and datapath.
// No dependencies.
package olid_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int MODE_W   = 2;
  localparam int POS_W    = 6;
  localparam int WORD_W   = 32;
  localparam int FILL_W   = 7;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_RM_STEP,
    S_RM_MOVE,
    S_INS_STEP,
    S_INS_MOVE,
    S_RD_WAIT,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_NEXT,
    RD_PREV
  } rd_sel_t;

  typedef struct packed {
    logic    load_op;
    logic    res_set;
    status_t res_status;
    logic    res_word_load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_at_count;
    logic    wr_from_mem;
    logic    idx_load_pos;
    logic    idx_load_count;
    logic    idx_inc;
    logic    idx_dec;
    logic    count_inc;
    logic    count_dec;
    logic    out_load;
  } olid_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  pos_ok;
    logic  full;
    logic  rm_more;
    logic  ins_more;
    logic  out_free;
  } olid_stat_t;

endpackage

### src/olid_dp.sv
// Datapath of the ordered list: entry memory, fill count, operation and index
// registers, and the result register. Depends on olid_pkg.
module olid_dp
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  olid_cmd_t                cmd,
  output olid_stat_t               stat,
  input  logic [MODE_W-1:0]        mode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] word_in,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [WORD_W-1:0] word_out,
  output logic [FILL_W-1:0]        fill_count,
  output logic [STATUS_W-1:0]      status
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  mode_t             mode_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] res_word;
  status_t           res_status;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:  rd_addr = AW'(pos_q);
      RD_NEXT: rd_addr = idx + AW'(1);
      RD_PREV: rd_addr = idx - AW'(1);
      default: rd_addr = idx;
    endcase
  end

  assign wr_addr = cmd.wr_at_count ? AW'(count) : idx;
  assign wr_data = cmd.wr_from_mem ? rd_data : word_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      mode_q <= mode_t'(mode);
      pos_q  <= position;
      word_q <= word_in;
    end
    if (cmd.idx_load_pos) begin
      idx <= AW'(pos_q);
    end else if (cmd.idx_load_count) begin
      idx <= AW'(count);
    end else if (cmd.idx_inc) begin
      idx <= idx + AW'(1);
    end else if (cmd.idx_dec) begin
      idx <= idx - AW'(1);
    end
    if (cmd.load_op) begin
      res_word <= '0;
    end else if (cmd.res_word_load) begin
      res_word <= rd_data;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + CW'(1);
    end else if (cmd.count_dec) begin
      count <= count - CW'(1);
    end
  end

  // Result register: a finished result waits here while the next item is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      word_out   <= res_word;
      fill_count <= FILL_W'(count);
      status     <= res_status;
    end
  end

  assign stat.mode     = mode_q;
  assign stat.pos_ok   = CMPW'(pos_q) < CMPW'(count);
  assign stat.full     = count == CW'(CAPACITY);
  assign stat.rm_more  = (CW'(idx) + CW'(1)) < count;
  assign stat.ins_more = CMPW'(idx) > CMPW'(pos_q);
  assign stat.out_free = !result_valid || !result_stall;

endmodule

### src/olid_ctrl.sv
// Controller of the ordered list: sequences each operation and the entry moves
// of remove and insert, one read and one write per moved entry. Depends on olid_pkg.
module olid_ctrl
  import olid_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  olid_stat_t stat,
  output olid_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (stat.mode)
          MODE_APPEND: state_next = S_FIN;
          MODE_REMOVE: state_next = stat.pos_ok ? S_RM_STEP : S_FIN;
          MODE_INSERT: state_next = (stat.pos_ok && !stat.full) ? S_INS_STEP : S_FIN;
          MODE_READ:   state_next = stat.pos_ok ? S_RD_WAIT : S_FIN;
          default:     state_next = S_FIN;
        endcase
      end
      S_RM_STEP:  state_next = stat.rm_more ? S_RM_MOVE : S_FIN;
      S_RM_MOVE:  state_next = S_RM_STEP;
      S_INS_STEP: state_next = stat.ins_more ? S_INS_MOVE : S_FIN;
      S_INS_MOVE: state_next = S_INS_STEP;
      S_RD_WAIT:  state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        item_stall  = 1'b0;
        cmd.load_op = item_valid;
      end
      S_DECIDE: begin
        cmd.res_set = 1'b1;
        unique case (stat.mode)
          MODE_APPEND: begin
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.res_status  = ST_DONE;
              cmd.wr_en       = 1'b1;
              cmd.wr_at_count = 1'b1;
              cmd.count_inc   = 1'b1;
            end
          end
          MODE_REMOVE: begin
            cmd.res_status   = stat.pos_ok ? ST_DONE : ST_RANGE;
            cmd.idx_load_pos = stat.pos_ok;
          end
          MODE_INSERT: begin
            // The position is checked before fullness.
            if (!stat.pos_ok) begin
              cmd.res_status = ST_RANGE;
            end else if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.res_status     = ST_DONE;
              cmd.idx_load_count = 1'b1;
            end
          end
          MODE_READ: begin
            cmd.res_status = stat.pos_ok ? ST_DONE : ST_RANGE;
            cmd.rd_en      = stat.pos_ok;
            cmd.rd_sel     = RD_POS;
          end
          default: cmd.res_status = ST_RANGE;
        endcase
      end
      S_RM_STEP: begin
        if (stat.rm_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT;
        end else begin
          cmd.count_dec = 1'b1;
        end
      end
      S_RM_MOVE: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_from_mem = 1'b1;
        cmd.idx_inc     = 1'b1;
      end
      S_INS_STEP: begin
        if (stat.ins_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
        end else begin
          // The index has come down to the insert position: place the new word.
          cmd.wr_en     = 1'b1;
          cmd.count_inc = 1'b1;
        end
      end
      S_INS_MOVE: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_from_mem = 1'b1;
        cmd.idx_dec     = 1'b1;
      end
      S_RD_WAIT: begin
        cmd.res_word_load = 1'b1;
      end
      S_FIN: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### src/ordered_list_insert_delete_top.sv
// Ordered list of up to CAPACITY signed 32-bit words held in a single-port-per-
// direction memory. One item is in work at a time. Remove moves fill - position - 1
// entries and insert moves fill - position entries, and every moved entry needs one
// memory read followed by one memory write. A finished result waits in an output
// register, and the next item is taken in while it does. Entries need no clearing
// after reset; the fill count starts at zero.
// Depends on olid_pkg, olid_ctrl and olid_dp.
module ordered_list_insert_delete_top
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] word_in,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [WORD_W-1:0] word_out,
  output logic [FILL_W-1:0]        fill_count,
  output logic [STATUS_W-1:0]      status
);

  olid_cmd_t  cmd;
  olid_stat_t stat;

  olid_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  olid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .position     (position),
    .word_in      (word_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .word_out     (word_out),
    .fill_count   (fill_count),
    .status       (status)
  );

endmodule

### src/olid_checker.sv
// Port-level checks for the ordered list, and the bind that attaches them to
// the top level. Depends on olid_pkg.
module olid_checker
  import olid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_stall,
  input logic [MODE_W-1:0]        mode,
  input logic [POS_W-1:0]         position,
  input logic signed [WORD_W-1:0] word_in,
  input logic                     result_valid,
  input logic                     result_stall,
  input logic signed [WORD_W-1:0] word_out,
  input logic [FILL_W-1:0]        fill_count,
  input logic [STATUS_W-1:0]      status
);

  // Only one item is in work, so a transfer in always closes the input for a while.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input taken on two consecutive cycles");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result withdrawn");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_DONE || status == ST_FULL || status == ST_RANGE))
    else $error("undefined status code");

  a_word_only_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && word_out != 0 |-> status == ST_DONE)
    else $error("non-zero word with a refused item");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (CAPACITY > 127) || (fill_count <= FILL_W'(CAPACITY)))
    else $error("fill count above capacity");

endmodule

bind ordered_list_insert_delete_top olid_checker #(.CAPACITY(CAPACITY)) u_olid_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for ordered_list_insert_delete_top: drives append, remove,
// insert and read items, predicts each result from a shadow list and compares them.
// Depends on olid_pkg and the ordered list RTL.
module testbench;
  import olid_pkg::*;

  localparam int LIST_CAP    = CAPACITY_DEF;
  localparam int ITEM_TOTAL  = 1800;
  localparam int TAIL_ITEMS  = 150;
  localparam int SETTLE      = 150;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    mode_t                    op;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word;
    bit                       drain;
  } list_op_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic [FILL_W-1:0]        fill;
    status_t                  status;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  logic [MODE_W-1:0]        mode = '0;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] word_in = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic signed [WORD_W-1:0] word_out;
  logic [FILL_W-1:0]        fill_count;
  logic [STATUS_W-1:0]      status;

  list_op_t     pending_ops[$];
  list_result_t due_results[$];

  // Shadow of the list contents, advanced as each item is taken in.
  logic signed [WORD_W-1:0] shadow_words[LIST_CAP];
  int                       shadow_fill = 0;

  // Fill level as seen by the stimulus generator, used to aim positions.
  int gen_fill = 0;

  list_op_t     in_flight;
  list_result_t due;
  int           gap_left = 0;
  int           gap_rate = 0;
  int           stall_left = 0;
  int           stall_rate = 0;
  int           items_taken = 0;
  int           results_seen = 0;
  int           quiet_cycles = 0;
  int           failures = 0;
  bit           timed_out = 1'b0;

  ordered_list_insert_delete_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .position     (position),
    .word_in      (word_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .word_out     (word_out),
    .fill_count   (fill_count),
    .status       (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic list_result_t list_apply(list_op_t it);
    list_result_t r;
    r.word   = '0;
    r.status = ST_DONE;
    case (it.op)
      MODE_APPEND: begin
        if (shadow_fill < LIST_CAP) begin
          shadow_words[shadow_fill] = it.word;
          shadow_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (it.pos < shadow_fill) begin
          for (int i = it.pos; i < shadow_fill - 1; i++) shadow_words[i] = shadow_words[i+1];
          shadow_fill--;
        end else begin
          r.status = ST_RANGE;
        end
      end
      MODE_INSERT: begin
        // The position is checked before the list is checked for room.
        if (it.pos >= shadow_fill) begin
          r.status = ST_RANGE;
        end else if (shadow_fill >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_fill; i > it.pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[it.pos] = it.word;
          shadow_fill++;
        end
      end
      default: begin
        if (it.pos < shadow_fill) r.word = shadow_words[it.pos];
        else r.status = ST_RANGE;
      end
    endcase
    r.fill = shadow_fill[FILL_W-1:0];
    return r;
  endfunction

  function automatic int pick_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 12;
      default: return 60;
    endcase
  endfunction

  function automatic void queue_op(mode_t op, int pos, logic signed [WORD_W-1:0] word,
                                   bit drain);
    list_op_t it;
    it.op    = op;
    it.pos   = pos[POS_W-1:0];
    it.word  = word;
    it.drain = drain;
    pending_ops.push_back(it);
    case (op)
      MODE_APPEND: if (gen_fill < LIST_CAP) gen_fill++;
      MODE_REMOVE: if (pos < gen_fill) gen_fill--;
      MODE_INSERT: if (pos < gen_fill && gen_fill < LIST_CAP) gen_fill++;
      default: ;
    endcase
  endfunction

  function automatic int pick_pos();
    if (gen_fill > 0 && $urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 5))
        0:       return 0;
        1:       return gen_fill - 1;
        default: return $urandom_range(0, gen_fill - 1);
      endcase
    end
    return $urandom_range(0, 63);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Item driver: fills a free slot with the next pending item, bar gaps and drains.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_valid && !item_stall) begin
        due_results.push_back(list_apply(in_flight));
        items_taken++;
        if (items_taken % 64 == 0) gap_rate = pick_rate();
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          item_valid <= 1'b0;
        end else if (pending_ops[0].drain && due_results.size() != 0) begin
          item_valid <= 1'b0;
        end else if (pending_ops.size() > TAIL_ITEMS && gap_rate != 0 &&
                     $urandom_range(0, 255) < gap_rate) begin
          gap_left = $urandom_range(0, 8);
          item_valid <= 1'b0;
        end else begin
          in_flight = pending_ops.pop_front();
          mode       <= in_flight.op;
          position   <= in_flight.pos;
          word_in    <= in_flight.word;
          item_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: checks each transfer against the oldest prediction and
  // stalls the result channel in random bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
      quiet_cycles = 0;
    end else begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (results_seen % 100 == 0) stall_rate = pick_rate();
        if (due_results.size() == 0) begin
          $error("unexpected result: word_out %0d fill_count %0d status %0d",
                 word_out, fill_count, status);
          failures++;
        end else begin
          due = due_results.pop_front();
          if (word_out !== due.word) begin
            $error("word_out: expected %0d, got %0d", due.word, word_out);
            failures++;
          end
          if (fill_count !== due.fill) begin
            $error("fill_count: expected %0d, got %0d", due.fill, fill_count);
            failures++;
          end
          if (status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status);
            failures++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (pending_ops.size() > TAIL_ITEMS && stall_rate != 0 &&
                   $urandom_range(0, 255) < stall_rate) begin
        stall_left = $urandom_range(0, 8);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int    kind;
    int    len;
    int    roll;
    mode_t op;
    bit    drain;

    // Directed opening: an empty list, word extremes, both ends of the list
    // and positions just past the filled range.
    queue_op(MODE_READ,   0,  '0, 1'b0);
    queue_op(MODE_REMOVE, 0,  '0, 1'b0);
    queue_op(MODE_INSERT, 0,  32'sd5, 1'b0);
    queue_op(MODE_APPEND, 0,  32'sh8000_0000, 1'b0);
    queue_op(MODE_APPEND, 63, 32'sh7FFF_FFFF, 1'b0);
    queue_op(MODE_APPEND, 0,  '0, 1'b0);
    queue_op(MODE_APPEND, 0,  -1, 1'b0);
    queue_op(MODE_READ,   0,  '0, 1'b0);
    queue_op(MODE_READ,   3,  '0, 1'b0);
    queue_op(MODE_READ,   4,  '0, 1'b0);
    queue_op(MODE_READ,   63, '0, 1'b0);
    queue_op(MODE_INSERT, 0,  32'sh1234_5678, 1'b0);
    queue_op(MODE_INSERT, 4,  32'shDEAD_BEEF, 1'b0);
    queue_op(MODE_INSERT, 6,  32'sh0BAD_F00D, 1'b0);
    queue_op(MODE_READ,   4,  '0, 1'b0);
    queue_op(MODE_REMOVE, 5,  '0, 1'b0);
    queue_op(MODE_REMOVE, 0,  '0, 1'b0);
    queue_op(MODE_REMOVE, 63, '0, 1'b0);
    queue_op(MODE_READ,   2,  '0, 1'b0);
    queue_op(MODE_READ,   3,  '0, 1'b0);

    // Random phases that push the list towards full, towards empty, or hold it.
    // The opening random item always waits for the directed results to drain.
    drain = 1'b1;
    while (pending_ops.size() < ITEM_TOTAL) begin
      kind = $urandom_range(0, 2);
      len  = $urandom_range(30, 120);
      for (int n = 0; n < len; n++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0:       op = roll < 50 ? MODE_APPEND : roll < 75 ? MODE_INSERT :
                        roll < 85 ? MODE_REMOVE : MODE_READ;
          1:       op = roll < 55 ? MODE_REMOVE : roll < 65 ? MODE_APPEND :
                        roll < 75 ? MODE_INSERT : MODE_READ;
          default: op = roll < 25 ? MODE_APPEND : roll < 50 ? MODE_INSERT :
                        roll < 75 ? MODE_REMOVE : MODE_READ;
        endcase
        queue_op(op, pick_pos(), pick_word(), drain);
        drain = (n == len - 1) && ($urandom_range(0, 2) == 0);
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (!timed_out &&
           (pending_ops.size() != 0 || item_valid || due_results.size() != 0)) begin
      @(posedge clk);
      if (quiet_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end

    if (timed_out) begin
      $error("no transfer on either channel for %0d cycles", STALL_LIMIT);
      $display("testbench NOT OK");
    end else begin
      repeat (SETTLE) @(posedge clk);
      if (failures == 0) $display("testbench OK");
      else $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
